/* rtl/streaming_difference_integrate_core_defines.svh */
// Assertion macros for the streaming difference/integrate core.
// Each macro expects signals named clk and rst_n in the calling scope.
`ifndef STREAMING_DIFFERENCE_INTEGRATE_CORE_DEFINES_SVH
`define STREAMING_DIFFERENCE_INTEGRATE_CORE_DEFINES_SVH

// Condition holds at every clock edge outside reset.
`define SDI_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define SDI_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define SDI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/sdi_pkg.sv */
// Shared constants for the streaming difference/integrate core.
// No dependencies.
package sdi_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int MAX_ORDER_DEF  = 4;
  localparam int ORD_W          = 3;

  localparam logic             CMD_DIFF  = 1'b0;
  localparam logic             CMD_INTEG = 1'b1;
  localparam logic [ORD_W-1:0] RST_ORDER = 3'd1;

endpackage

/* rtl/streaming_difference_integrate_core.sv */
// Streaming d-th order differencer / integrator with bit-serial saturating datapath.
// Depends on sdi_pkg and streaming_difference_integrate_core_defines.svh.
//
// Usage:
//   in_*  : sample beats; in_tuser[0] = cmd (0 difference, 1 integrate),
//           in_tdata = signed Q16.16 value.
//   out_* : one result beat per input beat; out_tdata = value,
//           out_tuser[0] = result valid, out_tuser[1] = primed.
//   cfg_* : writes diff_order; clears anchors and priming count.
// Passes: each order is one pass of DATA_WIDTH bits through the serial adder;
//   the result then waits in the done state and is loaded into the output register,
//   raising out_tvalid (order 0 goes straight to done). A priming difference stops
//   at the first pass whose anchor is not yet primed. One item is in work at a time.
// Reset: diff_order = 1, anchors and priming count cleared, no result pending.
// Stall: the result register holds until out_tready; a new input is taken
//   meanwhile, and its result waits in the done state until the register frees.
`include "streaming_difference_integrate_core_defines.svh"

module streaming_difference_integrate_core import sdi_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int MAX_ORDER  = MAX_ORDER_DEF,
  localparam int TDATA_W   = ((DATA_WIDTH + 7) / 8) * 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [TDATA_W-1:0] in_tdata,   // [DATA_WIDTH-1:0] in_value
  input  logic [0:0]         in_tuser,   // [0] cmd
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [TDATA_W-1:0] out_tdata,  // [DATA_WIDTH-1:0] out_value
  output logic [1:0]         out_tuser,  // [0] out_valid, [1] is_primed
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [ORD_W-1:0]   cfg_data
);

  localparam int CNT_W = $clog2(MAX_ORDER + 1);
  localparam int CW    = (CNT_W > ORD_W) ? CNT_W : ORD_W;
  localparam int IW    = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
  localparam int BW    = (DATA_WIDTH > 1) ? $clog2(DATA_WIDTH) : 1;
  localparam logic [CW-1:0] MAX_C    = CW'(MAX_ORDER);
  localparam logic [BW-1:0] LAST_BIT = BW'(DATA_WIDTH - 1);
  localparam logic [DATA_WIDTH-1:0] SAT_HI = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic [DATA_WIDTH-1:0] SAT_LO = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_DONE} state_t;

  state_t                state_r;
  logic [ORD_W-1:0]      order_r;
  logic [CW-1:0]         d_r;
  logic [CW-1:0]         pc_r;
  logic [IW-1:0]         idx_r;
  logic [BW-1:0]         bit_r;
  logic                  carry_r;
  logic                  cmd_r;
  logic                  valid_r;
  logic [DATA_WIDTH-1:0] acc_r;
  logic [DATA_WIDTH-1:0] anc_r [MAX_ORDER];
  logic                  out_tvalid_r;
  logic [DATA_WIDTH-1:0] out_value_r;
  logic                  out_valid_r;
  logic                  out_primed_r;

  logic [CW-1:0]         order_ext;
  logic [CW-1:0]         d_eff;
  logic [CW-1:0]         idx_ext;
  logic [CW-1:0]         pc_inc;
  logic                  a_bit;
  logic                  op_b;
  logic                  sum_bit;
  logic                  carry_nxt;
  logic                  ovf;
  logic                  last_bit;
  logic                  last_pass;
  logic                  prime_stop;
  logic                  out_free;
  logic [DATA_WIDTH-1:0] anc_cur;
  logic [DATA_WIDTH-1:0] acc_nxt;
  logic [DATA_WIDTH-1:0] anc_nxt;

  always_comb begin
    order_ext  = CW'(order_r);
    d_eff      = (order_ext > MAX_C) ? MAX_C : order_ext;
    idx_ext    = CW'(idx_r);
    pc_inc     = (pc_r < MAX_C) ? CW'(pc_r + 1'b1) : pc_r;
    anc_cur    = anc_r[idx_r];
    a_bit      = acc_r[0];
    op_b       = (cmd_r == CMD_INTEG) ? anc_cur[0] : ~anc_cur[0];
    sum_bit    = a_bit ^ op_b ^ carry_r;
    carry_nxt  = (a_bit & op_b) | (carry_r & (a_bit ^ op_b));
    last_bit   = (bit_r == LAST_BIT);
    ovf        = last_bit && (a_bit == op_b) && (sum_bit != a_bit);
    acc_nxt    = ovf ? (a_bit ? SAT_LO : SAT_HI) : {sum_bit, acc_r[DATA_WIDTH-1:1]};
    anc_nxt    = (cmd_r == CMD_INTEG) ?
                 (last_bit ? acc_nxt : {sum_bit, anc_cur[DATA_WIDTH-1:1]}) :
                 {a_bit, anc_cur[DATA_WIDTH-1:1]};
    last_pass  = (cmd_r == CMD_DIFF) ? (idx_ext == CW'(d_r - 1'b1)) : (idx_r == '0);
    prime_stop = (cmd_r == CMD_DIFF) && (bit_r == '0) && (pc_r <= idx_ext);
    out_free   = !out_tvalid_r || out_tready;
  end

  assign cfg_ready  = (state_r == S_IDLE);
  assign in_tready  = (state_r == S_IDLE) && !cfg_valid;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = TDATA_W'(out_value_r);
  assign out_tuser  = {out_primed_r, out_valid_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      order_r      <= RST_ORDER;
      pc_r         <= '0;
      out_tvalid_r <= 1'b0;
      for (int i = 0; i < MAX_ORDER; i++) begin
        anc_r[i] <= '0;
      end
    end else begin
      if ((state_r == S_DONE) && out_free) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (cfg_valid) begin
            order_r <= cfg_data;
            pc_r    <= '0;
            for (int i = 0; i < MAX_ORDER; i++) begin
              anc_r[i] <= '0;
            end
          end else if (in_tvalid) begin
            acc_r   <= in_tdata[DATA_WIDTH-1:0];
            cmd_r   <= in_tuser[0];
            d_r     <= d_eff;
            valid_r <= 1'b1;
            bit_r   <= '0;
            carry_r <= (in_tuser[0] == CMD_DIFF);
            idx_r   <= (in_tuser[0] == CMD_DIFF) ? '0 : IW'(d_eff - 1'b1);
            state_r <= (d_eff == '0) ? S_DONE : S_RUN;
          end
        end
        S_RUN: begin
          if (prime_stop) begin
            anc_r[idx_r] <= acc_r;
            pc_r         <= pc_inc;
            valid_r      <= 1'b0;
            state_r      <= S_DONE;
          end else begin
            acc_r        <= acc_nxt;
            anc_r[idx_r] <= anc_nxt;
            carry_r      <= last_bit ? (cmd_r == CMD_DIFF) : carry_nxt;
            bit_r        <= last_bit ? '0 : BW'(bit_r + 1'b1);
            if (last_bit) begin
              if (last_pass) begin
                state_r <= S_DONE;
                if (cmd_r == CMD_DIFF) begin
                  pc_r <= pc_inc;
                end
              end else begin
                idx_r <= (cmd_r == CMD_DIFF) ? IW'(idx_r + 1'b1) : IW'(idx_r - 1'b1);
              end
            end
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_value_r  <= valid_r ? acc_r : '0;
            out_valid_r  <= valid_r;
            out_primed_r <= (pc_r >= d_r);
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  `SDI_ASSERT_ALWAYS(a_pc_bound, pc_r <= MAX_C, "priming count above max order")
  `SDI_ASSERT_IMPLIES(a_invalid_zero, out_tvalid_r && !out_valid_r, out_value_r == '0,
                      "invalid result carries nonzero value")
  `SDI_ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, state_r != S_IDLE,
                   "core idle right after accepting a beat")

endmodule
